// File: rtl/srm_pkg.sv
// Shared types and constants for the SPI register access master.
// Holds sequencer step codes, request codes and the state/result structs.
// No dependencies.
package srm_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CS_SETUP = 4'd1;
  localparam logic [3:0] ST_W_PRE    = 4'd2;
  localparam logic [3:0] ST_W_LOW    = 4'd3;
  localparam logic [3:0] ST_W_HIGH   = 4'd4;
  localparam logic [3:0] ST_W_POST   = 4'd5;
  localparam logic [3:0] ST_R_PRE    = 4'd6;
  localparam logic [3:0] ST_R_HIGH   = 4'd7;
  localparam logic [3:0] ST_R_LOW    = 4'd8;
  localparam logic [3:0] ST_R_POST   = 4'd9;
  localparam logic [3:0] ST_CS_HOLD  = 4'd10;

  localparam logic [7:0] WRITE_FLAG = 8'h80;

  typedef struct packed {
    logic [3:0] step;
    logic [3:0] bit_cnt;
    logic [7:0] phase_cnt;
    logic [7:0] tx_shift;
    logic [7:0] rx_shift;
    logic [7:0] pending;
    logic       is_read;
  } srm_state_t;

  typedef struct packed {
    logic       spi_clock;
    logic       mosi_out;
    logic       select_n;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       rejected;
  } srm_result_t;

endpackage

// File: rtl/spi_register_access_master.sv
// Top level of the SPI mode-0 register access master.
// Depends on srm_pkg and srm_step.
//
// Each request is one time tick of a bit-banged SPI mode-0 master; a tick
// may also carry a register write or read. The sequencer state advances when
// a tick is accepted, and the pin levels and status for that tick land in a
// result register on that same edge. The block takes one tick every cycle;
// only a stalled, still-full result register holds off new ticks. Every
// clock half-phase and chip-select delay lasts phase_ticks ticks (0 acts
// as 1). Requests that arrive during a transaction are dropped and flagged.
module spi_register_access_master import srm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [6:0] reg_addr,
  input  logic [7:0] write_value,
  input  logic       miso_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       spi_clock,
  output logic       mosi_out,
  output logic       select_n,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_data,
  output logic       rejected
);

  logic [7:0]  phase_ticks;
  srm_state_t  state;
  srm_state_t  state_next;
  srm_result_t result_next;
  srm_result_t result;
  logic        accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  srm_step u_step (
    .state_cur   (state),
    .phase_ticks (phase_ticks),
    .command     (command),
    .reg_addr    (reg_addr),
    .write_value (write_value),
    .miso_in     (miso_in),
    .state_next  (state_next),
    .result      (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= 8'd1;
    end else if (cfg_write_en) begin
      phase_ticks <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign spi_clock = result.spi_clock;
  assign mosi_out  = result.mosi_out;
  assign select_n  = result.select_n;
  assign busy_res  = result.busy_res;
  assign done_res  = result.done_res;
  assign read_data = result.read_data;
  assign rejected  = result.rejected;

endmodule

// File: rtl/srm_step.sv
// One tick of the SPI mode-0 sequencer: next state and pin levels.
// Purely combinational; depends on srm_pkg.
module srm_step import srm_pkg::*; (
  input  srm_state_t  state_cur,
  input  logic [7:0]  phase_ticks,
  input  logic [1:0]  command,
  input  logic [6:0]  reg_addr,
  input  logic [7:0]  write_value,
  input  logic        miso_in,
  output srm_state_t  state_next,
  output srm_result_t result
);

  always_comb begin
    srm_state_t s;
    logic [7:0] limit;
    logic [7:0] pc_inc;
    s = state_cur;
    limit = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    result = '0;
    result.select_n = 1'b1;

    if (s.step > ST_CS_HOLD) begin
      s.step = ST_IDLE;
    end

    if (command inside {CMD_WRITE, CMD_READ}) begin
      if (s.step == ST_IDLE) begin
        s.is_read   = (command == CMD_READ);
        s.tx_shift  = (command == CMD_READ) ? {1'b0, reg_addr}
                                            : ({1'b0, reg_addr} | WRITE_FLAG);
        s.pending   = write_value;
        s.bit_cnt   = 4'd0;
        s.phase_cnt = 8'd0;
        s.step      = ST_CS_SETUP;
      end else begin
        result.rejected = 1'b1;
      end
    end

    pc_inc = s.phase_cnt + 8'd1;

    if (s.step != ST_IDLE) begin
      result.busy_res  = 1'b1;
      result.select_n  = (s.step == ST_CS_HOLD);
      result.spi_clock = (s.step == ST_W_HIGH) || (s.step == ST_R_HIGH);
      if ((s.step == ST_W_LOW) || (s.step == ST_W_HIGH)) begin
        result.mosi_out = s.tx_shift[7];
      end
      if (pc_inc >= limit) begin
        s.phase_cnt = 8'd0;
        case (s.step)
          ST_CS_SETUP: s.step = ST_W_PRE;
          ST_W_PRE:    s.step = ST_W_LOW;
          ST_W_LOW:    s.step = ST_W_HIGH;
          ST_W_HIGH: begin
            s.tx_shift = {s.tx_shift[6:0], 1'b0};
            s.bit_cnt  = s.bit_cnt + 4'd1;
            s.step     = (s.bit_cnt[2:0] == 3'd0) ? ST_W_POST : ST_W_LOW;
          end
          ST_W_POST: begin
            if (s.bit_cnt == 4'd8) begin
              if (s.is_read) begin
                s.step = ST_R_PRE;
              end else begin
                s.tx_shift = s.pending;
                s.step     = ST_W_PRE;
              end
            end else begin
              s.step = ST_CS_HOLD;
            end
          end
          ST_R_PRE:  s.step = ST_R_HIGH;
          ST_R_HIGH: begin
            s.rx_shift = {s.rx_shift[6:0], miso_in};
            s.bit_cnt  = s.bit_cnt + 4'd1;
            s.step     = ST_R_LOW;
          end
          ST_R_LOW:  s.step = (s.bit_cnt == 4'd0) ? ST_R_POST : ST_R_HIGH;
          ST_R_POST: s.step = ST_CS_HOLD;
          default: begin
            result.done_res = 1'b1;
            s.bit_cnt = 4'd0;
            s.step    = ST_IDLE;
          end
        endcase
      end else begin
        s.phase_cnt = pc_inc;
      end
    end

    result.read_data = s.rx_shift;
    state_next = s;
  end

endmodule

// File: test/spi_register_access_master_test.sv
`timescale 1ns / 1ps
// Testbench for spi_register_access_master: directed and random SPI ticks and requests.
// A scoreboard class models the sequencer tick by tick and checks every result.
// Depends on srm_pkg and the spi_register_access_master RTL.
module spi_register_access_master_test;
  import srm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  class spi_access_scoreboard;
    logic [7:0] half_ticks;
    logic [3:0] seq_step;
    logic [3:0] bits_done;
    logic [7:0] phase_count;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic [7:0] data_byte;
    logic       read_op;
    srm_result_t expected_pins[$];
    int errors;

    function new();
      half_ticks = 8'd1;
      seq_step = ST_IDLE;
      bits_done = '0;
      phase_count = '0;
      tx_byte = '0;
      rx_byte = '0;
      data_byte = '0;
      read_op = 1'b0;
      errors = 0;
    endfunction

    function bit busy();
      return seq_step != ST_IDLE;
    endfunction

    task report(string msg);
      if (errors < 40) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function void note_tick(logic [1:0] cmd, logic [6:0] addr, logic [7:0] wval, logic miso);
      srm_result_t pins;
      logic [7:0] limit_ticks;
      pins = '0;
      pins.select_n = 1'b1;
      limit_ticks = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
      if (seq_step > ST_CS_HOLD) seq_step = ST_IDLE;
      if (cmd == CMD_WRITE || cmd == CMD_READ) begin
        if (seq_step == ST_IDLE) begin
          read_op = (cmd == CMD_READ);
          tx_byte = read_op ? {1'b0, addr} : ({1'b0, addr} | WRITE_FLAG);
          data_byte = wval;
          bits_done = '0;
          phase_count = '0;
          seq_step = ST_CS_SETUP;
        end else begin
          pins.rejected = 1'b1;
        end
      end
      if (seq_step != ST_IDLE) begin
        pins.busy_res = 1'b1;
        pins.select_n = (seq_step == ST_CS_HOLD);
        pins.spi_clock = (seq_step == ST_W_HIGH || seq_step == ST_R_HIGH);
        if (seq_step == ST_W_LOW || seq_step == ST_W_HIGH) pins.mosi_out = tx_byte[7];
        phase_count = phase_count + 8'd1;
        if (phase_count >= limit_ticks) begin
          phase_count = '0;
          case (seq_step)
            ST_CS_SETUP: seq_step = ST_W_PRE;
            ST_W_PRE: seq_step = ST_W_LOW;
            ST_W_LOW: seq_step = ST_W_HIGH;
            ST_W_HIGH: begin
              tx_byte = tx_byte << 1;
              bits_done = bits_done + 4'd1;
              seq_step = (bits_done[2:0] == 3'd0) ? ST_W_POST : ST_W_LOW;
            end
            ST_W_POST: begin
              if (bits_done == 4'd8) begin
                if (read_op) begin
                  seq_step = ST_R_PRE;
                end else begin
                  tx_byte = data_byte;
                  seq_step = ST_W_PRE;
                end
              end else begin
                seq_step = ST_CS_HOLD;
              end
            end
            ST_R_PRE: seq_step = ST_R_HIGH;
            ST_R_HIGH: begin
              rx_byte = {rx_byte[6:0], miso};
              bits_done = bits_done + 4'd1;
              seq_step = ST_R_LOW;
            end
            ST_R_LOW: seq_step = (bits_done == 4'd0) ? ST_R_POST : ST_R_HIGH;
            ST_R_POST: seq_step = ST_CS_HOLD;
            default: begin
              pins.done_res = 1'b1;
              bits_done = '0;
              seq_step = ST_IDLE;
            end
          endcase
        end
      end
      pins.read_data = rx_byte;
      expected_pins.push_back(pins);
    endfunction

    task check_pins(srm_result_t got);
      srm_result_t want;
      if (expected_pins.size() == 0) begin
        report("result with no request pending");
        return;
      end
      want = expected_pins.pop_front();
      compare("spi_clock", 8'(got.spi_clock), 8'(want.spi_clock));
      compare("mosi_out", 8'(got.mosi_out), 8'(want.mosi_out));
      compare("select_n", 8'(got.select_n), 8'(want.select_n));
      compare("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      compare("done_res", 8'(got.done_res), 8'(want.done_res));
      compare("read_data", got.read_data, want.read_data);
      compare("rejected", 8'(got.rejected), 8'(want.rejected));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic [7:0] cfg_write_data = 8'd1;
  logic       in_valid = 1'b0;
  logic [1:0] command = CMD_TICK;
  logic [6:0] reg_addr = '0;
  logic [7:0] write_value = '0;
  logic       miso_in = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       spi_clock;
  logic       mosi_out;
  logic       select_n;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       rejected;

  int idle_pct = 0;
  int stall_pct = 0;
  spi_access_scoreboard board;

  spi_register_access_master DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .reg_addr(reg_addr),
    .write_value(write_value),
    .miso_in(miso_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .spi_clock(spi_clock),
    .mosi_out(mosi_out),
    .select_n(select_n),
    .busy_res(busy_res),
    .done_res(done_res),
    .read_data(read_data),
    .rejected(rejected)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_pins('{spi_clock, mosi_out, select_n, busy_res, done_res, read_data,
                         rejected});
    end
  end

  task automatic send_tick(logic [1:0] cmd, logic [6:0] addr, logic [7:0] wval, logic miso);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    reg_addr <= addr;
    write_value <= wval;
    miso_in <= miso;
    do @(posedge clk); while (in_stall);
    board.note_tick(cmd, addr, wval, miso);
  endtask

  // miso_mode: 0 low, 1 high, 2 random
  task automatic finish_transaction(int miso_mode);
    while (board.busy()) begin
      send_tick(CMD_TICK, 7'($urandom), 8'($urandom),
                (miso_mode == 2) ? 1'($urandom) : 1'(miso_mode));
    end
  endtask

  task automatic send_random();
    int k;
    logic [1:0] cmd;
    k = $urandom_range(99);
    if (board.busy()) begin
      if (k < 4) cmd = CMD_WRITE;
      else if (k < 8) cmd = CMD_READ;
      else if (k < 10) cmd = CMD_UNUSED;
      else cmd = CMD_TICK;
    end else begin
      if (k < 30) cmd = CMD_TICK;
      else if (k < 35) cmd = CMD_UNUSED;
      else if (k < 67) cmd = CMD_WRITE;
      else cmd = CMD_READ;
    end
    send_tick(cmd, 7'($urandom_range(127)), 8'($urandom_range(255)), 1'($urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_pins.size() != 0) @(posedge clk);
  endtask

  task automatic set_half_ticks(logic [7:0] value);
    settle();
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    board.half_ticks = value;
  endtask

  task automatic random_phase(logic [7:0] ticks, int idle, int stall, int count);
    set_half_ticks(ticks);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_random();
  endtask

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    board = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    send_tick(CMD_TICK, 7'h00, 8'h00, 1'b0);
    send_tick(CMD_UNUSED, 7'h7f, 8'hff, 1'b1);
    send_tick(CMD_WRITE, 7'h7f, 8'hff, 1'b1);
    send_tick(CMD_READ, 7'h12, 8'h34, 1'b0);
    send_tick(CMD_WRITE, 7'h55, 8'haa, 1'b1);
    finish_transaction(2);
    send_tick(CMD_WRITE, 7'h00, 8'h00, 1'b0);
    finish_transaction(0);
    send_tick(CMD_READ, 7'h00, 8'h00, 1'b1);
    finish_transaction(1);
    send_tick(CMD_READ, 7'h7f, 8'hff, 1'b0);
    finish_transaction(0);

    set_half_ticks(8'd0);
    send_tick(CMD_WRITE, 7'h2a, 8'h5a, 1'b0);
    finish_transaction(2);

    // longest set-up delay, then a short period for the rest of the read
    set_half_ticks(8'd255);
    send_tick(CMD_READ, 7'h41, 8'h00, 1'b1);
    repeat (256) send_tick(CMD_TICK, 7'h00, 8'h00, 1'b1);
    set_half_ticks(8'd1);
    finish_transaction(2);

    // period change while a write is in flight
    set_half_ticks(8'd2);
    send_tick(CMD_WRITE, 7'h33, 8'hc3, 1'b0);
    repeat (10) send_tick(CMD_TICK, 7'h00, 8'h00, 1'b1);
    set_half_ticks(8'd1);
    finish_transaction(2);

    random_phase(8'd1, 0, 0, 40);
    random_phase(8'd2, 54, 0, 40);
    random_phase(8'd1, 0, 54, 40);
    random_phase(8'd3, 35, 35, 40);
    random_phase(8'd0, 0, 0, 20);
    random_phase(8'd1, 35, 35, 30);

    settle();
    repeat (10) @(posedge clk);
    if (board.expected_pins.size() != 0) board.report("results never arrived");
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/srm_pkg.sv
rtl/srm_step.sv
rtl/spi_register_access_master.sv
test/spi_register_access_master_test.sv
